FILE: design/swhs_pkg.sv
package swhs_pkg;

  localparam int unsigned StartLowW  = 15;
  localparam int unsigned TickW      = 15;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned FrameW     = 40;
  localparam int unsigned BitCntW    = 6;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 15;

  localparam logic [BitCntW-1:0]   FrameBits        = 6'd40;
  localparam logic [StartLowW-1:0] StartLowReset    = 15'd20000;
  localparam logic [ByteW-1:0]     ReleaseReset     = 8'd30;
  localparam logic [ByteW-1:0]     TimeoutReset     = 8'd100;
  localparam logic [ByteW-1:0]     OneThreshReset   = 8'd40;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_START_LOW = 3'd1,
    PH_RELEASE   = 3'd2,
    PH_RESP_WAIT = 3'd3,
    PH_RESP_LOW  = 3'd4,
    PH_RESP_HIGH = 3'd5,
    PH_BIT_LOW   = 3'd6,
    PH_BIT_HIGH  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NORESP   = 2'd1,
    ST_BITTIME  = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_LOW  = 2'd0,
    CFG_RELEASE    = 2'd1,
    CFG_TIMEOUT    = 2'd2,
    CFG_ONE_THRESH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [StartLowW-1:0] start_low_ticks;
    logic [ByteW-1:0]     release_ticks;
    logic [ByteW-1:0]     timeout_ticks;
    logic [ByteW-1:0]     one_threshold_ticks;
  } cfg_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    status_e          status;
    logic [ByteW-1:0] humidity_whole;
    logic [ByteW-1:0] humidity_tenths;
    logic [ByteW-1:0] temperature_whole;
    logic [ByteW-1:0] temperature_tenths;
  } res_t;

endpackage

FILE: design/swhs_in_if.sv
interface swhs_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic line_level;

  modport source (output valid, output start_request, output line_level, input ready);
  modport sink   (input valid, input start_request, input line_level, output ready);
endinterface

FILE: design/swhs_out_if.sv
interface swhs_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] humidity_whole;
  logic [7:0] humidity_tenths;
  logic [7:0] temperature_whole;
  logic [7:0] temperature_tenths;

  modport source (
    output valid, output drive_low, output busy_res, output done_res, output status,
    output humidity_whole, output humidity_tenths, output temperature_whole,
    output temperature_tenths, input ready
  );
  modport sink (
    input valid, input drive_low, input busy_res, input done_res, input status,
    input humidity_whole, input humidity_tenths, input temperature_whole,
    input temperature_tenths, output ready
  );
endinterface

FILE: design/single_wire_humidity_sensor_reader_unit.sv
// Single-wire humidity sensor reader.
// in_i carries one item per microsecond tick: a start request and the sampled
// data line level. out_o returns exactly one result per input transfer: the
// line drive for that tick, busy and done flags, status and the four data bytes
// (valid on the done tick only).
// Each result is registered: in the output register, or in the skid register on a stall.
// Throughput: one item per cycle while in_i.ready is high; all decode work sits
// between the protocol state registers and the output register.
// Configuration: cfg_we_i writes register cfg_idx_i (0 start low, 1 release,
// 2 timeout, 3 one threshold) with cfg_data_i; write only while no reading is
// in progress and no result is outstanding.
// Reset: the reader goes idle, the output and skid registers empty and the
// configuration takes its default timing (20000, 30, 100, 40 ticks).
// Receiver stall: a skid register holds one further result, so in_i.ready
// stays high for one more transfer and then drops until out_o takes a transfer.
module single_wire_humidity_sensor_reader_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [swhs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [swhs_pkg::CfgDataW-1:0]      cfg_data_i,
  swhs_in_if.sink                            in_i,
  swhs_out_if.source                         out_o
);

  swhs_pkg::cfg_t cfg_q;
  swhs_pkg::res_t res;
  swhs_pkg::res_t out_q, skid_q;
  logic           out_valid_q, skid_valid_q;
  logic           in_fire, out_fire;

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && !skid_valid_q;
  assign out_fire   = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks     <= swhs_pkg::StartLowReset;
      cfg_q.release_ticks       <= swhs_pkg::ReleaseReset;
      cfg_q.timeout_ticks       <= swhs_pkg::TimeoutReset;
      cfg_q.one_threshold_ticks <= swhs_pkg::OneThreshReset;
    end else if (cfg_we_i) begin
      unique case (swhs_pkg::cfg_idx_e'(cfg_idx_i))
        swhs_pkg::CFG_START_LOW:  cfg_q.start_low_ticks     <= cfg_data_i[14:0];
        swhs_pkg::CFG_RELEASE:    cfg_q.release_ticks       <= cfg_data_i[7:0];
        swhs_pkg::CFG_TIMEOUT:    cfg_q.timeout_ticks       <= cfg_data_i[7:0];
        swhs_pkg::CFG_ONE_THRESH: cfg_q.one_threshold_ticks <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  swhs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (in_fire),
    .start_i (in_i.start_request),
    .line_i  (in_i.line_level),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_fire && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.drive_low          = out_q.drive_low;
  assign out_o.busy_res           = out_q.busy_res;
  assign out_o.done_res           = out_q.done_res;
  assign out_o.status             = out_q.status;
  assign out_o.humidity_whole     = out_q.humidity_whole;
  assign out_o.humidity_tenths    = out_q.humidity_tenths;
  assign out_o.temperature_whole  = out_q.temperature_whole;
  assign out_o.temperature_tenths = out_q.temperature_tenths;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_transfer_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("input transfer produced no pending result");
`endif

endmodule

FILE: design/swhs_ctrl.sv
module swhs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic          start_i,
  input  logic          line_i,
  input  swhs_pkg::cfg_t cfg_i,
  output swhs_pkg::res_t res_o
);

  swhs_pkg::phase_e                     phase_q, phase_d;
  logic [swhs_pkg::TickW-1:0]           ticks_q, ticks_d;
  logic [swhs_pkg::BitCntW-1:0]         bits_q, bits_d;
  logic [swhs_pkg::FrameW-1:0]          frame_q, frame_d;

  logic                                 drive;
  logic                                 fin;
  swhs_pkg::status_e                    fin_st;
  logic                                 weval;
  swhs_pkg::phase_e                     wph;
  swhs_pkg::phase_e                     nxt;
  logic [swhs_pkg::TickW-1:0]           wt;
  logic [swhs_pkg::TickW-1:0]           tick_inc;
  logic                                 waiting;
  logic                                 bit_val;
  logic                                 to_zero;

  logic [swhs_pkg::ByteW-1:0]           b0, b1, b2, b3, b4, sum8;
  swhs_pkg::status_e                    st_fin;

  assign tick_inc = ticks_q + swhs_pkg::TickW'(1);
  assign to_zero  = (cfg_i.timeout_ticks == '0);

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    bits_d  = bits_q;
    frame_d = frame_q;
    drive   = 1'b0;
    fin     = 1'b0;
    fin_st  = swhs_pkg::ST_OK;
    weval   = 1'b0;
    wph     = phase_q;
    wt      = ticks_q;
    waiting = 1'b0;
    bit_val = 1'b0;
    nxt     = swhs_pkg::PH_BIT_LOW;

    unique case (phase_q)
      swhs_pkg::PH_IDLE: begin
        if (start_i) begin
          drive   = 1'b1;
          bits_d  = '0;
          frame_d = '0;
          if (cfg_i.start_low_ticks <= swhs_pkg::StartLowW'(1)) begin
            phase_d = swhs_pkg::PH_RELEASE;
            ticks_d = '0;
          end else begin
            phase_d = swhs_pkg::PH_START_LOW;
            ticks_d = swhs_pkg::TickW'(1);
          end
        end
      end
      swhs_pkg::PH_START_LOW: begin
        drive = 1'b1;
        if (tick_inc >= cfg_i.start_low_ticks) begin
          phase_d = swhs_pkg::PH_RELEASE;
          ticks_d = '0;
        end else begin
          ticks_d = tick_inc;
        end
      end
      swhs_pkg::PH_RELEASE: begin
        if (ticks_q >= swhs_pkg::TickW'(cfg_i.release_ticks)) begin
          weval = 1'b1;
          wph   = swhs_pkg::PH_RESP_WAIT;
          wt    = '0;
        end else begin
          ticks_d = tick_inc;
        end
      end
      default: begin
        weval = 1'b1;
      end
    endcase

    if (weval) begin
      if (wph == swhs_pkg::PH_RESP_WAIT || wph == swhs_pkg::PH_RESP_HIGH ||
          wph == swhs_pkg::PH_BIT_HIGH) begin
        waiting = line_i;
      end else begin
        waiting = !line_i;
      end
      nxt = (wph == swhs_pkg::PH_BIT_HIGH) ? swhs_pkg::PH_BIT_LOW
                                           : swhs_pkg::phase_e'(3'(wph) + 3'd1);
      if (waiting) begin
        if (wt >= swhs_pkg::TickW'(cfg_i.timeout_ticks)) begin
          fin    = 1'b1;
          fin_st = (wph >= swhs_pkg::PH_BIT_LOW) ? swhs_pkg::ST_BITTIME
                                                 : swhs_pkg::ST_NORESP;
        end else begin
          phase_d = wph;
          ticks_d = wt + swhs_pkg::TickW'(1);
        end
      end else begin
        if (wph == swhs_pkg::PH_BIT_HIGH) begin
          bit_val = (ticks_q > swhs_pkg::TickW'(cfg_i.one_threshold_ticks));
          frame_d = {frame_q[swhs_pkg::FrameW-2:0], bit_val};
          bits_d  = bits_q + swhs_pkg::BitCntW'(1);
        end
        if (wph == swhs_pkg::PH_BIT_HIGH && bits_d >= swhs_pkg::FrameBits) begin
          fin    = 1'b1;
          fin_st = swhs_pkg::ST_OK;
        end else if (to_zero) begin
          // next phase opens already waiting, so a zero timeout fails at once
          fin    = 1'b1;
          fin_st = (nxt >= swhs_pkg::PH_BIT_LOW) ? swhs_pkg::ST_BITTIME
                                                 : swhs_pkg::ST_NORESP;
        end else begin
          phase_d = nxt;
          ticks_d = swhs_pkg::TickW'(1);
        end
      end
    end

    if (fin) begin
      phase_d = swhs_pkg::PH_IDLE;
      ticks_d = '0;
    end
  end

  assign b0   = frame_d[39:32];
  assign b1   = frame_d[31:24];
  assign b2   = frame_d[23:16];
  assign b3   = frame_d[15:8];
  assign b4   = frame_d[7:0];
  assign sum8 = b0 + b1 + b2 + b3;

  always_comb begin
    st_fin = fin_st;
    if (fin_st == swhs_pkg::ST_OK && sum8 != b4) begin
      st_fin = swhs_pkg::ST_CHECKSUM;
    end
    res_o.drive_low          = drive;
    res_o.busy_res           = (phase_d != swhs_pkg::PH_IDLE);
    res_o.done_res           = fin;
    res_o.status             = fin ? st_fin : swhs_pkg::ST_OK;
    res_o.humidity_whole     = '0;
    res_o.humidity_tenths    = '0;
    res_o.temperature_whole  = '0;
    res_o.temperature_tenths = '0;
    if (fin && fin_st == swhs_pkg::ST_OK) begin
      res_o.humidity_whole     = b0;
      res_o.humidity_tenths    = b1;
      res_o.temperature_whole  = b2;
      res_o.temperature_tenths = b3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= swhs_pkg::PH_IDLE;
      ticks_q <= '0;
      bits_q  <= '0;
      frame_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      bits_q  <= bits_d;
      frame_q <= frame_d;
    end
  end

`ifndef ASSERT_OFF
  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= swhs_pkg::FrameBits)
    else $error("bit count beyond frame length");

  a_idle_ticks_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == swhs_pkg::PH_IDLE |-> ticks_q == '0)
    else $error("tick counter not cleared while idle");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && res_o.done_res |=> phase_q == swhs_pkg::PH_IDLE)
    else $error("finished reading did not return to idle");

  a_hold_without_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> $stable(phase_q) && $stable(ticks_q))
    else $error("state moved without an input transfer");
`endif

endmodule

FILE: test/single_wire_humidity_sensor_reader_unit_tb.sv
`timescale 1ns / 100ps

import swhs_pkg::*;

class reading_tracker;
  cfg_t             timing;
  phase_e           phase;
  logic [TickW-1:0] ticks;
  logic [BitCntW-1:0] nbits;
  logic [FrameW-1:0]  shift;
  res_t             results_due[$];
  int unsigned      errors;
  int unsigned      readings;
  int unsigned      by_status[4];

  function new();
    timing = {StartLowReset, ReleaseReset, TimeoutReset, OneThreshReset};
    phase  = PH_IDLE;
    ticks  = '0;
    nbits  = '0;
    shift  = '0;
  endfunction

  function bit is_idle();
    return phase == PH_IDLE;
  endfunction

  function int unsigned pending();
    return results_due.size();
  endfunction

  function void close_reading(status_e st, inout res_t r);
    logic [ByteW-1:0] b[5];
    logic [ByteW-1:0] sum;
    int i;
    for (i = 0; i < 5; i++) b[i] = shift[FrameW-1-8*i -: 8];
    sum = b[0] + b[1] + b[2] + b[3];
    if (st == ST_OK && sum != b[4]) st = ST_CHECKSUM;
    r.done_res = 1'b1;
    r.status   = st;
    if (st == ST_OK || st == ST_CHECKSUM) begin
      r.humidity_whole     = b[0];
      r.humidity_tenths    = b[1];
      r.temperature_whole  = b[2];
      r.temperature_tenths = b[3];
    end
    phase = PH_IDLE;
    ticks = '0;
    readings++;
    by_status[st]++;
  endfunction

  // one tick in, one result out; up to four phase steps within a tick
  function void note_tick(bit start, bit line);
    res_t r;
    bit stop;
    bit want_high;
    bit waiting;
    int pass;
    r = '0;
    stop = 1'b0;
    if (phase == PH_IDLE) begin
      if (start) begin
        phase = PH_START_LOW;
        ticks = '0;
        nbits = '0;
        shift = '0;
      end else begin
        stop = 1'b1;
      end
    end
    for (pass = 0; pass < 4 && !stop; pass++) begin
      stop = 1'b1;
      case (phase)
        PH_IDLE: ;
        PH_START_LOW: begin
          r.drive_low = 1'b1;
          ticks = ticks + 1'b1;
          if (ticks >= timing.start_low_ticks) begin
            phase = PH_RELEASE;
            ticks = '0;
          end
        end
        PH_RELEASE: begin
          if (ticks >= timing.release_ticks) begin
            phase = PH_RESP_WAIT;
            ticks = '0;
            stop  = 1'b0;
          end else begin
            ticks = ticks + 1'b1;
          end
        end
        default: begin
          want_high = (phase == PH_RESP_WAIT) || (phase == PH_RESP_HIGH) ||
                      (phase == PH_BIT_HIGH);
          waiting = want_high ? line : !line;
          if (waiting) begin
            if (ticks >= timing.timeout_ticks)
              close_reading((phase >= PH_BIT_LOW) ? ST_BITTIME : ST_NORESP, r);
            else
              ticks = ticks + 1'b1;
          end else if (phase == PH_BIT_HIGH) begin
            shift = {shift[FrameW-2:0], (ticks > timing.one_threshold_ticks)};
            nbits = nbits + 1'b1;
            if (nbits >= FrameBits) begin
              close_reading(ST_OK, r);
            end else begin
              phase = PH_BIT_LOW;
              ticks = '0;
              stop  = 1'b0;
            end
          end else begin
            phase = phase_e'(phase + 1);
            ticks = '0;
            stop  = 1'b0;
          end
        end
      endcase
    end
    r.busy_res = !r.done_res && (phase != PH_IDLE);
    results_due.push_back(r);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (results_due.size() == 0) begin
      $display("%0t result %h arrived with nothing outstanding", $time, got);
      errors++;
      return;
    end
    want = results_due.pop_front();
    compare_field("drive_low", want.drive_low, got.drive_low);
    compare_field("busy_res", want.busy_res, got.busy_res);
    compare_field("done_res", want.done_res, got.done_res);
    compare_field("status", want.status, got.status);
    compare_field("humidity_whole", want.humidity_whole, got.humidity_whole);
    compare_field("humidity_tenths", want.humidity_tenths, got.humidity_tenths);
    compare_field("temperature_whole", want.temperature_whole, got.temperature_whole);
    compare_field("temperature_tenths", want.temperature_tenths, got.temperature_tenths);
  endfunction
endclass

module single_wire_humidity_sensor_reader_unit_tb;

  typedef enum int {
    RD_GOOD,
    RD_BAD_SUM,
    RD_NORESP,
    RD_BITTIME,
    RD_NOISE
  } reading_kind_e;

  localparam int unsigned QuietLimit = 1000;
  localparam int          RespSegs   = 3;
  localparam int          FrameSegs  = RespSegs + 2 * FrameBits;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  swhs_in_if  in_if();
  swhs_out_if out_if();

  single_wire_humidity_sensor_reader_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  reading_tracker sb = new();
  cfg_t        timing;
  bit          in_idle_on;
  bit          out_idle_on;
  bit          hold_done;
  int unsigned ticks_sent;
  int unsigned timing_sets;
  int unsigned out_hold;
  int unsigned quiet;
  res_t        seen;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (out_hold != 0) begin
      out_hold--;
    end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(1, 7);
    end
    out_if.ready <= (out_hold == 0);
  end

  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen.drive_low          = out_if.drive_low;
      seen.busy_res           = out_if.busy_res;
      seen.done_res           = out_if.done_res;
      seen.status             = status_e'(out_if.status);
      seen.humidity_whole     = out_if.humidity_whole;
      seen.humidity_tenths    = out_if.humidity_tenths;
      seen.temperature_whole  = out_if.temperature_whole;
      seen.temperature_tenths = out_if.temperature_tenths;
      sb.check_result(seen);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QuietLimit) begin
      $display("%0t no transfer for %0d cycles", $time, quiet);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_tick(bit start, bit line);
    if (in_idle_on && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.start_request <= start;
    in_if.line_level    <= line;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_tick(start, line);
    ticks_sent++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic retime(int unsigned low_t, int unsigned rel_t, int unsigned tmo_t,
                        int unsigned thr_t);
    logic [CfgDataW-1:0] word;
    cfg_idx_e idx;
    int i;
    settle();
    timing.start_low_ticks     = StartLowW'(low_t);
    timing.release_ticks       = ByteW'(rel_t);
    timing.timeout_ticks       = ByteW'(tmo_t);
    timing.one_threshold_ticks = ByteW'(thr_t);
    for (i = 0; i < 4; i++) begin
      idx  = cfg_idx_e'(i);
      word = CfgDataW'($urandom);
      case (idx)
        CFG_START_LOW:  word = timing.start_low_ticks;
        CFG_RELEASE:    word[ByteW-1:0] = timing.release_ticks;
        CFG_TIMEOUT:    word[ByteW-1:0] = timing.timeout_ticks;
        CFG_ONE_THRESH: word[ByteW-1:0] = timing.one_threshold_ticks;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= word;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sb.timing = timing;
    timing_sets++;
  endtask

  function automatic int unsigned clip(int unsigned n);
    if (n > timing.timeout_ticks) n = timing.timeout_ticks;
    return (n == 0) ? 1 : n;
  endfunction

  // sensor side of one reading; segments 0..2 are the response, then low/high per bit
  task automatic read_frame(reading_kind_e kind);
    logic [FrameW-1:0] frame;
    int bad_seg;
    int seg;
    int unsigned n;
    bit level;
    bit one;
    frame[FrameW-1:ByteW] = $urandom;
    frame[ByteW-1:0] = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
    if (kind == RD_BAD_SUM) frame[ByteW-1:0] ^= 8'($urandom_range(1, 255));
    bad_seg = -1;
    if (kind == RD_NORESP) bad_seg = $urandom_range(0, RespSegs - 1);
    if (kind == RD_BITTIME) bad_seg = $urandom_range(RespSegs, FrameSegs - 1);
    if (kind == RD_NOISE) begin
      repeat ($urandom_range(10, 60))
        send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 1));
    end else begin
      send_tick(1'b1, $urandom_range(0, 1));
      n = (timing.start_low_ticks > 1) ? timing.start_low_ticks - 1 : 0;
      repeat (n) send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 1));
      repeat (timing.release_ticks)
        send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 1));
      for (seg = 0; seg < FrameSegs; seg++) begin
        level = (seg == 1) ? 1'b0 : (seg < RespSegs) ? 1'b1 : bit'((seg - RespSegs) & 1);
        if (seg == bad_seg) begin
          n = timing.timeout_ticks + 1;
        end else if (seg == 0) begin
          n = $urandom_range(0, 3);
          if (n > timing.timeout_ticks) n = timing.timeout_ticks;
        end else if (seg > RespSegs && level) begin
          one = frame[FrameW - 1 - (seg - RespSegs - 1) / 2];
          if (one)
            n = clip(timing.one_threshold_ticks + 1 + $urandom_range(0, 2));
          else if ($urandom_range(0, 1))
            n = clip(timing.one_threshold_ticks);
          else
            n = clip($urandom_range(1, timing.one_threshold_ticks));
        end else begin
          n = ($urandom_range(0, 7) == 0) ? clip(255) : clip($urandom_range(1, 4));
        end
        repeat (n) send_tick($urandom_range(0, 15) == 0, level);
        if (seg == bad_seg) break;
        if (!hold_done && seg == RespSegs + FrameBits) begin
          in_if.valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk_i);
          hold_done = 1'b1;
        end
      end
      // falling edge after the last high phase closes the frame
      if (bad_seg < 0) send_tick($urandom_range(0, 3) == 0, 1'b0);
    end
    while (!sb.is_idle()) send_tick(1'b0, 1'b1);
    repeat ($urandom_range(0, 3)) send_tick(1'b0, $urandom_range(0, 1));
  endtask

  initial begin
    int unsigned left;
    int unsigned tmo;
    int unsigned pick;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_START_LOW;
    cfg_data_i          = '0;
    in_if.valid         = 1'b0;
    in_if.start_request = 1'b0;
    in_if.line_level    = 1'b1;
    out_if.ready        = 1'b0;
    timing = {StartLowReset, ReleaseReset, TimeoutReset, OneThreshReset};
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    retime(0, 0, 20, 0);
    read_frame(RD_GOOD);
    read_frame(RD_NORESP);
    retime(3, 255, 1, 255);
    read_frame(RD_GOOD);
    retime(1, 0, 0, 0);
    read_frame(RD_GOOD);
    read_frame(RD_NORESP);
    read_frame(RD_NOISE);

    left = 0;
    while (ticks_sent < 1150) begin
      if (left == 0) begin
        tmo = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        retime(($urandom_range(0, 15) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 6),
               ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 5),
               tmo, $urandom_range(0, tmo));
        left = $urandom_range(4, 8);
      end
      left--;
      in_idle_on  = $urandom_range(0, 2) != 0;
      out_idle_on = $urandom_range(0, 2) != 0;
      pick = $urandom_range(0, 19);
      if (pick < 11)
        read_frame(RD_GOOD);
      else if (pick < 13)
        read_frame(RD_BAD_SUM);
      else if (pick < 15)
        read_frame(RD_NORESP);
      else if (pick < 17)
        read_frame(RD_BITTIME);
      else
        read_frame(RD_NOISE);
    end

    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    retime(3, 2, 8, 3);
    read_frame(RD_GOOD);
    read_frame(RD_BAD_SUM);
    settle();

    $display("%0d ticks over %0d timing sets, %0d readings finished", ticks_sent,
             timing_sets, sb.readings);
    $display("outcomes: %0d ok, %0d no response, %0d bit timeout, %0d bad checksum",
             sb.by_status[ST_OK], sb.by_status[ST_NORESP], sb.by_status[ST_BITTIME],
             sb.by_status[ST_CHECKSUM]);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: single_wire_humidity_sensor_reader_unit.f
design/swhs_pkg.sv
design/swhs_in_if.sv
design/swhs_out_if.sv
design/swhs_ctrl.sv
design/single_wire_humidity_sensor_reader_unit.sv
test/single_wire_humidity_sensor_reader_unit_tb.sv
